>>> hdl/tmcc_pkg.sv
// ----------------------------------------------------------------------------
// Contour cell package
// Shared widths, payload word types and the triangle case table.
// ----------------------------------------------------------------------------
package tmcc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 4;
    localparam int INDEX_BITS  = 12;
    localparam int OUT_BITS    = COORD_BITS + FRAC_BITS;
    localparam int H_BITS      = SAMPLE_BITS + 3;
    localparam int P_BITS      = H_BITS + OUT_BITS + 1;
    localparam int Q_BITS      = P_BITS + 1;

    localparam logic [3:0] K_NONE = 4'd0;
    localparam logic [3:0] K_AB   = 4'd1;
    localparam logic [3:0] K_BC   = 4'd2;
    localparam logic [3:0] K_CA   = 4'd3;
    localparam logic [3:0] K_ABC  = 4'd4;
    localparam logic [3:0] K_BCA  = 4'd5;
    localparam logic [3:0] K_CAB  = 4'd6;
    localparam logic [3:0] K_XAB  = 4'd7;
    localparam logic [3:0] K_XBC  = 4'd8;
    localparam logic [3:0] K_XCA  = 4'd9;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] corner_bl;
        logic signed [SAMPLE_BITS-1:0] corner_br;
        logic signed [SAMPLE_BITS-1:0] corner_tr;
        logic signed [SAMPLE_BITS-1:0] corner_tl;
        logic signed [COORD_BITS-1:0]  x_left;
        logic signed [COORD_BITS-1:0]  x_right;
        logic signed [COORD_BITS-1:0]  y_bottom;
        logic signed [COORD_BITS-1:0]  y_top;
        logic signed [SAMPLE_BITS-1:0] level;
        logic [INDEX_BITS-1:0]         cell_col;
        logic [INDEX_BITS-1:0]         cell_row;
    } t_cell;

    typedef struct packed {
        logic signed [OUT_BITS-1:0]    start_x;
        logic signed [OUT_BITS-1:0]    start_y;
        logic signed [OUT_BITS-1:0]    end_x;
        logic signed [OUT_BITS-1:0]    end_y;
        logic signed [SAMPLE_BITS-1:0] seg_level;
        logic [INDEX_BITS-1:0]         tag_col;
        logic [INDEX_BITS-1:0]         tag_row;
        logic                          last;
    } t_seg;

    // Signs are coded 0 negative, 1 zero, 2 positive.
    function automatic logic [3:0] seg_case(input logic [1:0] a, input logic [1:0] b,
                                            input logic [1:0] c);
        logic [4:0] idx;
        logic [3:0] k;
        idx = 5'(a) * 5'd9 + 5'(b) * 5'd3 + 5'(c);
        case (idx)
            5'd2:  k = K_XBC;
            5'd4:  k = K_BC;
            5'd5:  k = K_BCA;
            5'd6:  k = K_XAB;
            5'd7:  k = K_CAB;
            5'd8:  k = K_XCA;
            5'd10: k = K_CA;
            5'd11: k = K_ABC;
            5'd12: k = K_AB;
            5'd13: k = K_CA;
            5'd14: k = K_AB;
            5'd15: k = K_ABC;
            5'd16: k = K_CA;
            5'd18: k = K_XCA;
            5'd19: k = K_CAB;
            5'd20: k = K_XAB;
            5'd21: k = K_BCA;
            5'd22: k = K_BC;
            5'd24: k = K_XBC;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] sgn_code(input logic signed [H_BITS-1:0] h);
        return (h == '0) ? 2'd1 : (h[H_BITS-1] ? 2'd0 : 2'd2);
    endfunction

endpackage

>>> hdl/tmcc_div.sv
// ----------------------------------------------------------------------------
// Contour cell divider
// Pipelined restoring divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module tmcc_div
    import tmcc_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [P_BITS-1:0]  i_num,
    input  logic signed [H_BITS:0]    i_den,
    output logic signed [OUT_BITS-1:0] o_quo
);
    localparam int NB = P_BITS;
    localparam int DB = H_BITS + 1;

    logic [NB-1:0] r_q   [0:NB];
    logic [DB-1:0] r_rem [0:NB];
    logic [DB-1:0] r_d   [0:NB];
    logic          r_neg [0:NB];

    always_ff @(posedge i_clk) begin
        r_q[0]    <= i_num[NB-1] ? NB'(-i_num) : NB'(i_num);
        r_rem[0]  <= '0;
        r_d[0]    <= i_den[DB-1] ? DB'(-i_den) : DB'(i_den);
        r_neg[0]  <= i_num[NB-1] ^ i_den[DB-1];
    end

    for (genvar g = 0; g < NB; g++) begin : g_st
        logic [DB:0] n_t;
        assign n_t = {r_rem[g], r_q[g][NB-1]};
        always_ff @(posedge i_clk) begin
            if (n_t >= {1'b0, r_d[g]}) begin
                r_rem[g+1] <= DB'(n_t - {1'b0, r_d[g]});
                r_q[g+1]   <= {r_q[g][NB-2:0], 1'b1};
            end else begin
                r_rem[g+1] <= DB'(n_t);
                r_q[g+1]   <= {r_q[g][NB-2:0], 1'b0};
            end
            r_d[g+1]    <= r_d[g];
            r_neg[g+1]  <= r_neg[g];
        end
    end

    assign o_quo = r_neg[NB] ? OUT_BITS'(-r_q[NB]) : OUT_BITS'(r_q[NB]);
endmodule

>>> hdl/triangle_mesh_contour_cell.sv
// ----------------------------------------------------------------------------
// Triangle mesh contour cell
// Emits up to four contour segments for one grid cell and one level.
// ----------------------------------------------------------------------------
// A cell word is accepted when i_start is high and o_busy is low. Each cell
// occupies the block while the triangle counter steps through its four
// triangles, so o_busy is high after an accepted word until the counter
// returns to zero, and a new cell may follow directly after that. The four
// triangles stream through a deep pipeline: a setup stage, a sign and case
// stage, a selection stage, a product stage, a pipelined divider of one
// quotient bit per stage, and an output register. Each segment word appears
// on o_seg for one cycle marked by o_valid, with last set on the final
// segment of its cell. The words of a cell come out in triangle order. Cells
// whose level lies outside the corner range produce no words. Reset clears
// all valid bits and the triangle counter. The receiver cannot stall; words
// are never held.
// ----------------------------------------------------------------------------
module triangle_mesh_contour_cell
    import tmcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_cell i_cell,
    output logic  o_busy,
    output logic  o_valid,
    output t_seg  o_seg
);
    localparam int DL = P_BITS + 1;

    // Stage 1: capture and form heights and coordinates.
    logic [1:0] r_cnt;
    logic       r_v1;
    logic signed [H_BITS-1:0]   r_h [0:4];
    logic signed [OUT_BITS-1:0] r_x [0:4];
    logic signed [OUT_BITS-1:0] r_y [0:4];
    logic signed [SAMPLE_BITS-1:0] r_lvl1;
    logic [INDEX_BITS-1:0] r_col1, r_row1;

    logic signed [SAMPLE_BITS:0] d0, d1, d2, d3;
    logic acc;
    assign acc = i_start && !o_busy;
    assign o_busy = (r_cnt != 2'd0);
    always_comb begin
        d0 = (SAMPLE_BITS+1)'(i_cell.corner_bl) - (SAMPLE_BITS+1)'(i_cell.level);
        d1 = (SAMPLE_BITS+1)'(i_cell.corner_br) - (SAMPLE_BITS+1)'(i_cell.level);
        d2 = (SAMPLE_BITS+1)'(i_cell.corner_tr) - (SAMPLE_BITS+1)'(i_cell.level);
        d3 = (SAMPLE_BITS+1)'(i_cell.corner_tl) - (SAMPLE_BITS+1)'(i_cell.level);
    end
    logic in_rng;
    assign in_rng = !((d0 > 0 && d1 > 0 && d2 > 0 && d3 > 0) ||
                      (d0 < 0 && d1 < 0 && d2 < 0 && d3 < 0));

    logic signed [OUT_BITS:0] sx, sy;
    assign sx = (OUT_BITS+1)'(i_cell.x_left) + (OUT_BITS+1)'(i_cell.x_right);
    assign sy = (OUT_BITS+1)'(i_cell.y_bottom) + (OUT_BITS+1)'(i_cell.y_top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_v1  <= 1'b0;
        end else begin
            if (acc) r_cnt <= 2'd1;
            else if (r_cnt != 2'd0) r_cnt <= r_cnt + 2'd1;
            if (acc) r_v1 <= in_rng;
        end
        if (acc) begin
            r_h[1] <= H_BITS'(d0) <<< 2;
            r_h[2] <= H_BITS'(d1) <<< 2;
            r_h[3] <= H_BITS'(d2) <<< 2;
            r_h[4] <= H_BITS'(d3) <<< 2;
            r_h[0] <= H_BITS'(d0) + H_BITS'(d1) + H_BITS'(d2) + H_BITS'(d3);
            r_x[1] <= OUT_BITS'(i_cell.x_left)   <<< FRAC_BITS;
            r_x[4] <= OUT_BITS'(i_cell.x_left)   <<< FRAC_BITS;
            r_x[2] <= OUT_BITS'(i_cell.x_right)  <<< FRAC_BITS;
            r_x[3] <= OUT_BITS'(i_cell.x_right)  <<< FRAC_BITS;
            r_y[1] <= OUT_BITS'(i_cell.y_bottom) <<< FRAC_BITS;
            r_y[2] <= OUT_BITS'(i_cell.y_bottom) <<< FRAC_BITS;
            r_y[3] <= OUT_BITS'(i_cell.y_top)    <<< FRAC_BITS;
            r_y[4] <= OUT_BITS'(i_cell.y_top)    <<< FRAC_BITS;
            r_x[0] <= OUT_BITS'((sx <<< FRAC_BITS) >>> 1) +
                      OUT_BITS'((FRAC_BITS == 0) && sx[OUT_BITS] && sx[0]);
            r_y[0] <= OUT_BITS'((sy <<< FRAC_BITS) >>> 1) +
                      OUT_BITS'((FRAC_BITS == 0) && sy[OUT_BITS] && sy[0]);
            r_lvl1 <= i_cell.level;
            r_col1 <= i_cell.cell_col;
            r_row1 <= i_cell.cell_row;
        end
    end

    // Stage 2: pick triangle m = r_ph phase, look up its case.
    logic [1:0] tri_i;
    logic [2:0] va, vc;
    logic active;
    // Triangle phase starts at zero in the cycle after acceptance and runs alongside the counter.
    logic [1:0] r_ph;
    logic       r_act;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= '0;
            r_act <= 1'b0;
        end else begin
            if (acc) begin
                r_ph  <= '0;
                r_act <= 1'b1;
            end else if (r_act) begin
                r_ph  <= r_ph + 2'd1;
                r_act <= (r_ph != 2'd3);
            end
        end
    end
    assign tri_i  = r_ph;
    assign active = r_act && r_v1;
    assign va = 3'(tri_i) + 3'd1;
    assign vc = (tri_i == 2'd3) ? 3'd1 : 3'(tri_i) + 3'd2;

    // A triangle closes its cell when no later triangle has a segment.
    logic [3:0] k_any;
    logic       tri_last;
    assign k_any[0] = (seg_case(sgn_code(r_h[1]), sgn_code(r_h[0]),
                                sgn_code(r_h[2])) != K_NONE);
    assign k_any[1] = (seg_case(sgn_code(r_h[2]), sgn_code(r_h[0]),
                                sgn_code(r_h[3])) != K_NONE);
    assign k_any[2] = (seg_case(sgn_code(r_h[3]), sgn_code(r_h[0]),
                                sgn_code(r_h[4])) != K_NONE);
    assign k_any[3] = (seg_case(sgn_code(r_h[4]), sgn_code(r_h[0]),
                                sgn_code(r_h[1])) != K_NONE);
    always_comb begin
        case (tri_i)
            2'd0: tri_last = !(|k_any[3:1]);
            2'd1: tri_last = !(|k_any[3:2]);
            2'd2: tri_last = !k_any[3];
            default: tri_last = 1'b1;
        endcase
    end

    logic r_v2;
    logic [3:0] r_k2;
    logic signed [H_BITS-1:0]   r_ha, r_hb, r_hc;
    logic signed [OUT_BITS-1:0] r_xa, r_xb, r_xc, r_ya, r_yb, r_yc;
    logic r_lastph2;
    logic signed [SAMPLE_BITS-1:0] r_lvl2;
    logic [INDEX_BITS-1:0] r_col2, r_row2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else r_v2 <= active;
        r_k2 <= seg_case(sgn_code(r_h[va]), sgn_code(r_h[0]), sgn_code(r_h[vc]));
        r_ha <= r_h[va]; r_hb <= r_h[0]; r_hc <= r_h[vc];
        r_xa <= r_x[va]; r_xb <= r_x[0]; r_xc <= r_x[vc];
        r_ya <= r_y[va]; r_yb <= r_y[0]; r_yc <= r_y[vc];
        r_lastph2 <= tri_last;
        r_lvl2 <= r_lvl1; r_col2 <= r_col1; r_row2 <= r_row1;
    end

    // Stage 3: choose vertices or crossing pairs for each end point.
    // sel code per end: 0..2 vertex a,b,c; 4..6 crossing ab, bc, ca.
    logic [2:0] sa, se;
    always_comb begin
        case (r_k2)
            K_AB:  begin sa = 3'd0; se = 3'd1; end
            K_BC:  begin sa = 3'd1; se = 3'd2; end
            K_CA:  begin sa = 3'd2; se = 3'd0; end
            K_ABC: begin sa = 3'd0; se = 3'd5; end
            K_BCA: begin sa = 3'd1; se = 3'd6; end
            K_CAB: begin sa = 3'd2; se = 3'd4; end
            K_XAB: begin sa = 3'd4; se = 3'd5; end
            K_XBC: begin sa = 3'd5; se = 3'd6; end
            K_XCA: begin sa = 3'd6; se = 3'd4; end
            default: begin sa = 3'd0; se = 3'd0; end
        endcase
    end

    logic r_v3;
    logic r_lastph3;
    logic [2:0] r_sa, r_se;
    logic signed [H_BITS-1:0]   r3_h [0:2];
    logic signed [OUT_BITS-1:0] r3_x [0:2];
    logic signed [OUT_BITS-1:0] r3_y [0:2];
    logic signed [SAMPLE_BITS-1:0] r_lvl3;
    logic [INDEX_BITS-1:0] r_col3, r_row3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else r_v3 <= r_v2 && (r_k2 != K_NONE);
        r_lastph3 <= r_lastph2;
        r_sa <= sa; r_se <= se;
        r3_h[0] <= r_ha; r3_h[1] <= r_hb; r3_h[2] <= r_hc;
        r3_x[0] <= r_xa; r3_x[1] <= r_xb; r3_x[2] <= r_xc;
        r3_y[0] <= r_ya; r3_y[1] <= r_yb; r3_y[2] <= r_yc;
        r_lvl3 <= r_lvl2; r_col3 <= r_col2; r_row3 <= r_row2;
    end

    // Stage 4: products for the crossings (Hq*Xp - Hp*Xq).
    function automatic logic [1:0] p_of(input logic [2:0] s);
        return (s == 3'd4) ? 2'd0 : ((s == 3'd5) ? 2'd1 : 2'd2);
    endfunction
    function automatic logic [1:0] q_of(input logic [2:0] s);
        return (s == 3'd4) ? 2'd1 : ((s == 3'd5) ? 2'd2 : 2'd0);
    endfunction

    logic [1:0] ap, aq, ep, eq;
    assign ap = p_of(r_sa); assign aq = q_of(r_sa);
    assign ep = p_of(r_se); assign eq = q_of(r_se);

    logic r_v4, r_lastph4, r_ac, r_ec;
    logic signed [P_BITS-1:0] r_m [0:7];
    logic signed [H_BITS:0]   r_den_a, r_den_e;
    logic signed [OUT_BITS-1:0] r_fax, r_fay, r_fex, r_fey;
    logic signed [SAMPLE_BITS-1:0] r_lvl4;
    logic [INDEX_BITS-1:0] r_col4, r_row4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else r_v4 <= r_v3;
        r_lastph4 <= r_lastph3;
        r_ac <= r_sa[2]; r_ec <= r_se[2];
        r_m[0] <= P_BITS'(r3_h[aq]) * P_BITS'(r3_x[ap]);
        r_m[1] <= P_BITS'(r3_h[ap]) * P_BITS'(r3_x[aq]);
        r_m[2] <= P_BITS'(r3_h[aq]) * P_BITS'(r3_y[ap]);
        r_m[3] <= P_BITS'(r3_h[ap]) * P_BITS'(r3_y[aq]);
        r_m[4] <= P_BITS'(r3_h[eq]) * P_BITS'(r3_x[ep]);
        r_m[5] <= P_BITS'(r3_h[ep]) * P_BITS'(r3_x[eq]);
        r_m[6] <= P_BITS'(r3_h[eq]) * P_BITS'(r3_y[ep]);
        r_m[7] <= P_BITS'(r3_h[ep]) * P_BITS'(r3_y[eq]);
        r_den_a <= (H_BITS+1)'(r3_h[aq]) - (H_BITS+1)'(r3_h[ap]);
        r_den_e <= (H_BITS+1)'(r3_h[eq]) - (H_BITS+1)'(r3_h[ep]);
        r_fax <= r_sa[2] ? r3_x[ap] : r3_x[r_sa[1:0]];
        r_fay <= r_sa[2] ? r3_y[ap] : r3_y[r_sa[1:0]];
        r_fex <= r_se[2] ? r3_x[ep] : r3_x[r_se[1:0]];
        r_fey <= r_se[2] ? r3_y[ep] : r3_y[r_se[1:0]];
        r_lvl4 <= r_lvl3; r_col4 <= r_col3; r_row4 <= r_row3;
    end

    // Stage 5 onward: four dividers in parallel, side data delayed alongside.
    logic signed [OUT_BITS-1:0] q_ax, q_ay, q_ex, q_ey;
    tmcc_div u_dax (.i_clk, .i_num(r_m[0] - r_m[1]), .i_den(r_den_a), .o_quo(q_ax));
    tmcc_div u_day (.i_clk, .i_num(r_m[2] - r_m[3]), .i_den(r_den_a), .o_quo(q_ay));
    tmcc_div u_dex (.i_clk, .i_num(r_m[4] - r_m[5]), .i_den(r_den_e), .o_quo(q_ex));
    tmcc_div u_dey (.i_clk, .i_num(r_m[6] - r_m[7]), .i_den(r_den_e), .o_quo(q_ey));

    localparam int SW = 4 * OUT_BITS + 2 * INDEX_BITS + SAMPLE_BITS + 3;
    logic [SW-1:0] r_sd [0:DL-1];
    logic [DL-1:0] r_vd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vd <= '0;
        else r_vd <= {r_vd[DL-2:0], r_v4};
        r_sd[0] <= {r_fax, r_fay, r_fex, r_fey, r_lvl4, r_col4, r_row4,
                    r_ac, r_ec, r_lastph4};
        for (int i = 1; i < DL; i++) r_sd[i] <= r_sd[i-1];
    end

    logic signed [OUT_BITS-1:0] sd_fax, sd_fay, sd_fex, sd_fey;
    logic signed [SAMPLE_BITS-1:0] sd_lvl;
    logic [INDEX_BITS-1:0] sd_col, sd_row;
    logic sd_ac, sd_ec, sd_lp;
    assign {sd_fax, sd_fay, sd_fex, sd_fey, sd_lvl, sd_col, sd_row, sd_ac, sd_ec, sd_lp} =
        r_sd[DL-1];

    // A vertex end point bypasses the dividers and comes from the side data.
    logic signed [OUT_BITS-1:0] n_ax, n_ay, n_ex, n_ey;
    assign n_ax = sd_ac ? q_ax : sd_fax;
    assign n_ay = sd_ac ? q_ay : sd_fay;
    assign n_ex = sd_ec ? q_ex : sd_fex;
    assign n_ey = sd_ec ? q_ey : sd_fey;

    logic r_ov;
    t_seg r_out;
    logic vin;
    assign vin = r_vd[DL-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else r_ov <= vin;
        r_out <= '{start_x: n_ax, start_y: n_ay, end_x: n_ex, end_y: n_ey,
                   seg_level: sd_lvl, tag_col: sd_col, tag_row: sd_row, last: sd_lp};
    end

    assign o_valid = r_ov;
    assign o_seg   = r_out;
endmodule

>>> hdl/tmcc_check.sv
// ----------------------------------------------------------------------------
// Contour cell checker
// Port level properties of the contour cell, bound to the top level.
// ----------------------------------------------------------------------------
module tmcc_check
    import tmcc_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_start,
    input logic  o_busy,
    input logic  o_valid,
    input t_seg  o_seg
);
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("busy not raised");
    a_busy3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##2 o_busy) else $error("busy too short");
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##3 !o_busy) else $error("busy too long");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
endmodule

bind triangle_mesh_contour_cell tmcc_check u_check (.*);
